/* rtl/lss_pkg.sv */
// Package for the search stack: sizes, op and status codes, result record.
`default_nettype none

package lss_pkg;

    // Store geometry
    localparam int DEPTH       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int MADE_W      = $clog2(MAX_RESULTS + 1);
    localparam int OP_W        = 3;
    localparam int DIST_W      = 6;
    localparam int COUNT_W     = 7;

    // Op codes
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  element;
        logic [DIST_W-1:0]         from_top;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/lss_store.sv */
// Stack word store: one write port, one registered read port.
`default_nettype none

module lss_store (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [lss_pkg::ADDR_W-1:0]         waddr,
    input  wire logic signed [lss_pkg::DATA_W-1:0]  wdata,
    input  wire logic                               re,
    input  wire logic [lss_pkg::ADDR_W-1:0]         raddr,
    output logic signed [lss_pkg::DATA_W-1:0]       rdata
);

    logic signed [lss_pkg::DATA_W-1:0] mem [lss_pkg::DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lifo_stack_with_search_top.sv */
// Top level of the bounded stack with search and display.
//
// Input channel (in_valid, in_stall, op, value): one item per operation.
// Output channel (out_valid, out_stall, status, element, depth_from_top,
// element_count, last): one or more result items per input item (none for an
// unused op code); last marks the final one.
// Push, clear and the empty cases of pop, peek and display give their result
// in the output register in the cycle after acceptance, and a new item can be
// taken every cycle while the output side keeps up. Pop and peek pass their
// top word through the registered read port of the store and S_TOP_OUT first.
// Search and display step through the store one element at a time (a read,
// then a compare in the shared comparator), and a final state closes the
// walk. Each matching result is held back one step so that last can be set
// on the true final one; at most MAX_RESULTS results are given per item.
// Reset empties the stack; the store contents are not cleared and are never
// read before being written.
// While out_stall holds a waiting result, the sequencer pauses as soon as it
// has another result to hand over, and in_stall stays high until the output
// register can be reloaded.
`default_nettype none

module lifo_stack_with_search_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [lss_pkg::OP_W-1:0]           op,
    input  wire logic signed [lss_pkg::DATA_W-1:0]  value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic signed [lss_pkg::DATA_W-1:0]       element,
    output logic [lss_pkg::DIST_W-1:0]              depth_from_top,
    output logic [lss_pkg::COUNT_W-1:0]             element_count,
    output logic                                    last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP_OUT,
        S_WALK_RD,
        S_WALK_CMP,
        S_WALK_END
    } state_t;

    state_t                              state_reg, state_next;
    logic [lss_pkg::OP_W-1:0]            op_reg, op_next;
    logic signed [lss_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [lss_pkg::FILL_W-1:0]          fill_reg, fill_next;
    logic [lss_pkg::FILL_W-1:0]          idx_reg, idx_next;
    logic [lss_pkg::MADE_W-1:0]          made_reg, made_next;
    logic                                pend_valid_reg, pend_valid_next;
    lss_pkg::result_t                    pend_reg, pend_next;
    logic                                out_valid_reg, out_valid_next;
    lss_pkg::result_t                    out_reg, out_next;

    logic                                mem_we;
    logic [lss_pkg::ADDR_W-1:0]          mem_waddr;
    logic                                mem_re;
    logic [lss_pkg::ADDR_W-1:0]          mem_raddr;
    logic signed [lss_pkg::DATA_W-1:0]   mem_rdata;

    logic                                can_load;
    logic [lss_pkg::FILL_W-1:0]          walk_rev;
    logic [lss_pkg::FILL_W-1:0]          top_count;
    logic                                hit;

    lss_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register free, or emptied this cycle
    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && can_load);

    // shared index unit: distance from the top, and the match compare
    assign walk_rev  = fill_reg - lss_pkg::FILL_W'(1) - idx_reg;
    assign hit       = (op_reg == lss_pkg::OP_DISPLAY) || (mem_rdata == value_reg);
    assign top_count = (op_reg == lss_pkg::OP_POP) ? (fill_reg - lss_pkg::FILL_W'(1))
                                                   : fill_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        made_next       = made_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_reg[lss_pkg::ADDR_W-1:0];
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[lss_pkg::ADDR_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && can_load)
                begin
                    op_next         = op;
                    value_next      = value;
                    idx_next        = '0;
                    made_next       = '0;
                    pend_valid_next = 1'b0;
                    unique case (op)
                        lss_pkg::OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (fill_reg == lss_pkg::FILL_W'(lss_pkg::DEPTH))
                            begin
                                out_next = '{lss_pkg::ST_FULL, value, '0,
                                             lss_pkg::COUNT_W'(fill_reg), 1'b1};
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + lss_pkg::FILL_W'(1);
                                out_next  = '{lss_pkg::ST_OK, value, '0,
                                              lss_pkg::COUNT_W'(fill_next), 1'b1};
                            end
                        end
                        lss_pkg::OP_POP, lss_pkg::OP_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{lss_pkg::ST_EMPTY, '0, '0, '0, 1'b1};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = lss_pkg::ADDR_W'(fill_reg - lss_pkg::FILL_W'(1));
                                state_next = S_TOP_OUT;
                            end
                        end
                        lss_pkg::OP_SEARCH:
                        begin
                            state_next = S_WALK_RD;
                        end
                        lss_pkg::OP_DISPLAY:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{lss_pkg::ST_EMPTY, '0, '0, '0, 1'b1};
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        lss_pkg::OP_CLEAR:
                        begin
                            fill_next      = '0;
                            out_valid_next = 1'b1;
                            out_next       = '{lss_pkg::ST_OK, '0, '0, '0, 1'b1};
                        end
                        default:
                        begin
                            // unused codes: no result, no change
                        end
                    endcase
                end
            end

            // pop or peek: top word is in the read register
            S_TOP_OUT:
            begin
                if (can_load)
                begin
                    fill_next      = top_count;
                    out_valid_next = 1'b1;
                    out_next       = '{lss_pkg::ST_OK, mem_rdata, '0,
                                       lss_pkg::COUNT_W'(top_count), 1'b1};
                    state_next     = S_IDLE;
                end
            end

            // issue the read for the next element, or close the walk
            S_WALK_RD:
            begin
                if ((idx_reg == fill_reg)
                    || (made_reg == lss_pkg::MADE_W'(lss_pkg::MAX_RESULTS)))
                begin
                    state_next = S_WALK_END;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (op_reg == lss_pkg::OP_DISPLAY)
                                 ? walk_rev[lss_pkg::ADDR_W-1:0]
                                 : idx_reg[lss_pkg::ADDR_W-1:0];
                    state_next = S_WALK_CMP;
                end
            end

            // compare; a hit releases the held result and takes its place
            S_WALK_CMP:
            begin
                if (!hit)
                begin
                    idx_next   = idx_reg + lss_pkg::FILL_W'(1);
                    state_next = S_WALK_RD;
                end
                else if (!pend_valid_reg || can_load)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    if (op_reg == lss_pkg::OP_DISPLAY)
                    begin
                        pend_next = '{lss_pkg::ST_OK, mem_rdata,
                                      lss_pkg::DIST_W'(idx_reg),
                                      lss_pkg::COUNT_W'(fill_reg), 1'b0};
                    end
                    else
                    begin
                        pend_next = '{lss_pkg::ST_OK, value_reg,
                                      lss_pkg::DIST_W'(walk_rev),
                                      lss_pkg::COUNT_W'(fill_reg), 1'b0};
                    end
                    made_next  = made_reg + lss_pkg::MADE_W'(1);
                    idx_next   = idx_reg + lss_pkg::FILL_W'(1);
                    state_next = S_WALK_RD;
                end
            end

            // final result of the walk
            S_WALK_END:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = '{lss_pkg::ST_NOTFOUND, value_reg, '0,
                                     lss_pkg::COUNT_W'(fill_reg), 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            value_reg      <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            made_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            value_reg      <= value_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            made_reg       <= made_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign element        = out_reg.element;
    assign depth_from_top = out_reg.from_top;
    assign element_count  = out_reg.count;
    assign last           = out_reg.last;

endmodule

`default_nettype wire
